### rtl/mscs_pkg.sv
// ----------------------------------------------------------------------------
// mscs_pkg
// types, edge codes and segment table for the marching squares cell unit
// ----------------------------------------------------------------------------
package mscs_pkg;

    localparam int LevelW    = 16;
    localparam int CoordW    = 24;
    localparam int FracBits  = 16;            // fraction bits of the crossing point
    localparam int DenW      = LevelW + 1;    // level difference
    localparam int InterpLat = FracBits + 2;  // edge unit: divide stages, multiply, round

    typedef enum logic [1:0] {
        EDGE_A = 2'd0,
        EDGE_B = 2'd1,
        EDGE_C = 2'd2,
        EDGE_D = 2'd3
    } t_edge;

    typedef struct packed {
        logic signed [LevelW-1:0] level_00;
        logic signed [LevelW-1:0] level_01;
        logic signed [LevelW-1:0] level_10;
        logic signed [LevelW-1:0] level_11;
        logic signed [CoordW-1:0] x_low;
        logic signed [CoordW-1:0] x_high;
        logic signed [CoordW-1:0] y_low;
        logic signed [CoordW-1:0] y_high;
    } t_cell;

    typedef struct packed {
        logic signed [CoordW-1:0] start_x;
        logic signed [CoordW-1:0] start_y;
        logic signed [CoordW-1:0] end_x;
        logic signed [CoordW-1:0] end_y;
        logic                     last_segment;
    } t_seg;

    // per-key segment plan: segment total and edge codes e0 to e3
    typedef struct packed {
        logic [1:0] count;
        t_edge      e0;
        t_edge      e1;
        t_edge      e2;
        t_edge      e3;
    } t_plan;

    function automatic t_plan plan_lookup(input logic [3:0] key);
        t_plan p;
        p = '{count: 2'd0, e0: EDGE_A, e1: EDGE_A, e2: EDGE_A, e3: EDGE_A};
        unique case (key)
            4'd0, 4'd15: p.count = 2'd0;
            4'd1:  begin p.count = 2'd1; p.e0 = EDGE_B; p.e1 = EDGE_A; end
            4'd2:  begin p.count = 2'd1; p.e0 = EDGE_B; p.e1 = EDGE_C; end
            4'd3:  begin p.count = 2'd1; p.e0 = EDGE_A; p.e1 = EDGE_C; end
            4'd4:  begin p.count = 2'd1; p.e0 = EDGE_A; p.e1 = EDGE_D; end
            4'd5:  begin p.count = 2'd1; p.e0 = EDGE_B; p.e1 = EDGE_D; end
            4'd6:  begin
                p.count = 2'd2; p.e0 = EDGE_B; p.e1 = EDGE_C;
                p.e2 = EDGE_A; p.e3 = EDGE_D;
            end
            4'd7:  begin p.count = 2'd1; p.e0 = EDGE_C; p.e1 = EDGE_D; end
            4'd8:  begin p.count = 2'd1; p.e0 = EDGE_C; p.e1 = EDGE_D; end
            4'd9:  begin
                p.count = 2'd2; p.e0 = EDGE_C; p.e1 = EDGE_D;
                p.e2 = EDGE_B; p.e3 = EDGE_A;
            end
            4'd10: begin p.count = 2'd1; p.e0 = EDGE_B; p.e1 = EDGE_D; end
            4'd11: begin p.count = 2'd1; p.e0 = EDGE_A; p.e1 = EDGE_D; end
            4'd12: begin p.count = 2'd1; p.e0 = EDGE_A; p.e1 = EDGE_C; end
            4'd13: begin p.count = 2'd1; p.e0 = EDGE_B; p.e1 = EDGE_C; end
            4'd14: begin p.count = 2'd1; p.e0 = EDGE_A; p.e1 = EDGE_B; end
            default: p.count = 2'd0;
        endcase
        return p;
    endfunction

endpackage

### rtl/mscs_edge_interp.sv
// ----------------------------------------------------------------------------
// mscs_edge_interp
// pipelined crossing point on one cell edge: restoring divide then scale
// ----------------------------------------------------------------------------
// stage 0 registers the folded numerator/denominator, then one quotient bit
// per stage (16 stages), then multiply, then round and add into the output
// register. i_en advances every stage.
module mscs_edge_interp (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [mscs_pkg::LevelW-1:0]  i_iso,
    input  logic signed [mscs_pkg::LevelW-1:0]  i_la,
    input  logic signed [mscs_pkg::LevelW-1:0]  i_lb,
    input  logic signed [mscs_pkg::CoordW-1:0]  i_ca,
    input  logic signed [mscs_pkg::CoordW-1:0]  i_cb,
    output logic signed [mscs_pkg::CoordW-1:0]  o_coord
);
    localparam int NS = mscs_pkg::FracBits;   // quotient bits
    localparam int DW = mscs_pkg::DenW;
    localparam int CW = mscs_pkg::CoordW;
    localparam int PW = CW + NS + 2;          // product width

    // front end: signed numerator and denominator with signs folded
    logic signed [DW-1:0] w_num, w_den;
    logic                 w_zero, w_sat;
    always_comb begin
        w_num = DW'(i_iso) - DW'(i_lb);
        w_den = DW'(i_la)  - DW'(i_lb);
        if (w_den < 0) begin
            w_den = -w_den;
            w_num = -w_num;
        end
        w_zero = (w_den == '0) || (w_num <= 0);
        // numerator at or above the denominator means a full fraction
        w_sat  = !w_zero && (w_num >= w_den);
    end

    // divider pipe: remainder, quotient so far, divisor and passengers
    logic [DW-1:0]        r_rem  [NS+1];
    logic [NS-1:0]        r_quo  [NS+1];
    logic [DW-1:0]        r_den  [NS+1];
    logic                 r_zero [NS+1];
    logic                 r_sat  [NS+1];
    logic signed [CW-1:0] r_ca   [NS+1];
    logic signed [CW-1:0] r_cb   [NS+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= w_num[DW-1:0];
            r_quo[0]  <= '0;
            r_den[0]  <= w_den[DW-1:0];
            r_zero[0] <= w_zero;
            r_sat[0]  <= w_sat;
            r_ca[0]   <= i_ca;
            r_cb[0]   <= i_cb;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar s = 0; s < NS; s++) begin : g_div
        logic [DW:0] w_shl, w_sub;
        logic        w_ge;
        always_comb begin
            w_shl = {r_rem[s], 1'b0};
            w_sub = w_shl - {1'b0, r_den[s]};
            w_ge  = (w_shl >= {1'b0, r_den[s]});
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1]  <= w_ge ? w_sub[DW-1:0] : w_shl[DW-1:0];
                r_quo[s+1]  <= {r_quo[s][NS-2:0], w_ge};
                r_den[s+1]  <= r_den[s];
                r_zero[s+1] <= r_zero[s];
                r_sat[s+1]  <= r_sat[s];
                r_ca[s+1]   <= r_ca[s];
                r_cb[s+1]   <= r_cb[s];
            end
        end
    end

    // fraction 0 .. 2^16
    logic [NS:0] w_frac;
    always_comb begin
        if (r_zero[NS])     w_frac = '0;
        else if (r_sat[NS]) w_frac = {1'b1, {NS{1'b0}}};
        else                w_frac = {1'b0, r_quo[NS]};
    end

    // multiply stage: 17 bit fraction by 25 bit signed span
    logic signed [CW:0]    w_diff;
    logic signed [PW-1:0]  w_fx, w_dx;
    logic signed [PW-1:0]  r_prod;
    logic signed [CW-1:0]  r_cb_m;
    always_comb begin
        w_diff = (CW+1)'(r_ca[NS]) - (CW+1)'(r_cb[NS]);
        w_fx   = signed'({{(PW-NS-1){1'b0}}, w_frac});
        w_dx   = PW'(w_diff);
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_fx * w_dx;
            r_cb_m <= r_cb[NS];
        end
    end

    // round (half up) and add; arithmetic shift gives the floor
    logic signed [PW-1:0] w_rnd;
    always_comb begin
        w_rnd = (r_prod + (PW'(32'sd1) <<< (NS - 1))) >>> NS;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) o_coord <= r_cb_m + w_rnd[CW-1:0];
    end

endmodule

### rtl/marching_squares_cell_segments.sv
// ----------------------------------------------------------------------------
// marching_squares_cell_segments
// one grid cell in, up to two contour segments out
// ----------------------------------------------------------------------------
// channel | dir | handshake        | beat
// cfg     | in  | valid / ready    | iso level, 16 bit signed
// cell    | in  | start / busy     | t_cell: four corner levels, cell box
// segment | out | strobe only      | t_seg: endpoints and last flag
//
// the first segment beat of a cell reaches the ports from the edge that takes
// it through the key and front stage, 16 divide stages, multiply, round and
// add, and the output register. a second segment follows in the next cycle.
// a cell can be taken every cycle; each cell with two segments costs one
// stall cycle when it reaches the output: busy is high for that cycle and
// the whole pipe holds. the rate is set by the single output port.
// the receiver cannot stall; the pipe only pauses on busy.
// reset clears valid bits and the iso level.
module marching_squares_cell_segments (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  mscs_pkg::t_cell       i_cell,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [mscs_pkg::LevelW-1:0] i_cfg_data,
    output logic                  o_seg_strobe,
    output mscs_pkg::t_seg        o_seg
);
    localparam int Lat = mscs_pkg::InterpLat;   // interp latency

    logic signed [mscs_pkg::LevelW-1:0] r_iso;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_iso <= '0;
        else if (i_cfg_valid) r_iso <= signed'(i_cfg_data);
    end

    // pipe advance: stalls only while a second segment is pending
    logic w_en, w_take;
    logic r_hold;              // second segment pending in output
    assign w_en   = !r_hold;
    assign busy   = r_hold;
    assign w_take = start && !busy;

    // key stage (combinational from input, registered with the pipe)
    logic [3:0]  w_key;
    logic signed [mscs_pkg::LevelW+2:0] w_sum;
    always_comb begin
        w_key[0] = i_cell.level_00 >= r_iso;
        w_key[1] = i_cell.level_01 >= r_iso;
        w_key[2] = i_cell.level_10 >= r_iso;
        w_key[3] = i_cell.level_11 >= r_iso;
        w_sum = 19'(i_cell.level_00) + 19'(i_cell.level_01)
              + 19'(i_cell.level_10) + 19'(i_cell.level_11);
        if (w_sum > (19'(r_iso) <<< 2)) begin
            if (w_key == 4'd6)      w_key = 4'd9;
            else if (w_key == 4'd9) w_key = 4'd6;
        end
    end

    // edge units u_a to u_d, each on its own cell edge
    logic signed [mscs_pkg::CoordW-1:0] w_pt [4];
    mscs_edge_interp u_a (.i_clk, .i_en(w_en), .i_iso(r_iso),
        .i_la(i_cell.level_00), .i_lb(i_cell.level_10),
        .i_ca(i_cell.x_low), .i_cb(i_cell.x_high), .o_coord(w_pt[0]));
    mscs_edge_interp u_b (.i_clk, .i_en(w_en), .i_iso(r_iso),
        .i_la(i_cell.level_00), .i_lb(i_cell.level_01),
        .i_ca(i_cell.y_low), .i_cb(i_cell.y_high), .o_coord(w_pt[1]));
    mscs_edge_interp u_c (.i_clk, .i_en(w_en), .i_iso(r_iso),
        .i_la(i_cell.level_01), .i_lb(i_cell.level_11),
        .i_ca(i_cell.x_low), .i_cb(i_cell.x_high), .o_coord(w_pt[2]));
    mscs_edge_interp u_d (.i_clk, .i_en(w_en), .i_iso(r_iso),
        .i_la(i_cell.level_10), .i_lb(i_cell.level_11),
        .i_ca(i_cell.y_low), .i_cb(i_cell.y_high), .o_coord(w_pt[3]));

    // side pipe: valid, plan and fixed box coordinates
    logic                 r_v    [Lat+1];
    mscs_pkg::t_plan      r_plan [Lat+1];
    logic signed [mscs_pkg::CoordW-1:0] r_xl [Lat+1], r_xh [Lat+1];
    logic signed [mscs_pkg::CoordW-1:0] r_yl [Lat+1], r_yh [Lat+1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= Lat; k++) r_v[k] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= w_take;
            for (int k = 1; k <= Lat; k++) r_v[k] <= r_v[k-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_plan[0] <= mscs_pkg::plan_lookup(w_key);
            r_xl[0] <= i_cell.x_low;  r_xh[0] <= i_cell.x_high;
            r_yl[0] <= i_cell.y_low;  r_yh[0] <= i_cell.y_high;
            for (int k = 1; k <= Lat; k++) begin
                r_plan[k] <= r_plan[k-1];
                r_xl[k] <= r_xl[k-1]; r_xh[k] <= r_xh[k-1];
                r_yl[k] <= r_yl[k-1]; r_yh[k] <= r_yh[k-1];
            end
        end
    end

    // endpoint of one edge code at the pipe end
    function automatic logic [2*mscs_pkg::CoordW-1:0] point(
        input mscs_pkg::t_edge e,
        input logic signed [mscs_pkg::CoordW-1:0] pa, pb, pc, pd,
        input logic signed [mscs_pkg::CoordW-1:0] xl, xh, yl, yh);
        logic [2*mscs_pkg::CoordW-1:0] r;
        unique case (e)
            mscs_pkg::EDGE_A: r = {pa, yl};
            mscs_pkg::EDGE_B: r = {xl, pb};
            mscs_pkg::EDGE_C: r = {pc, yh};
            mscs_pkg::EDGE_D: r = {xh, pd};
            default:          r = '0;
        endcase
        return r;
    endfunction

    // the edge units' outputs line up with the last side pipe stage
    mscs_pkg::t_plan w_p;
    logic [2*mscs_pkg::CoordW-1:0] w_s0, w_e0, w_s1, w_e1;
    always_comb begin
        w_p  = r_plan[Lat];
        w_s0 = point(w_p.e0, w_pt[0], w_pt[1], w_pt[2], w_pt[3],
                     r_xl[Lat], r_xh[Lat], r_yl[Lat], r_yh[Lat]);
        w_e0 = point(w_p.e1, w_pt[0], w_pt[1], w_pt[2], w_pt[3],
                     r_xl[Lat], r_xh[Lat], r_yl[Lat], r_yh[Lat]);
        w_s1 = point(w_p.e2, w_pt[0], w_pt[1], w_pt[2], w_pt[3],
                     r_xl[Lat], r_xh[Lat], r_yl[Lat], r_yh[Lat]);
        w_e1 = point(w_p.e3, w_pt[0], w_pt[1], w_pt[2], w_pt[3],
                     r_xl[Lat], r_xh[Lat], r_yl[Lat], r_yh[Lat]);
    end

    // output register; second segment parked in r_second for the hold beat
    mscs_pkg::t_seg r_second;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_seg_strobe <= 1'b0;
            r_hold       <= 1'b0;
        end else if (r_hold) begin
            o_seg_strobe <= 1'b1;
            r_hold       <= 1'b0;
        end else begin
            o_seg_strobe <= r_v[Lat] && (w_p.count != 2'd0);
            r_hold       <= r_v[Lat] && (w_p.count == 2'd2);
        end
    end
    always_ff @(posedge i_clk) begin
        if (r_hold) begin
            o_seg <= r_second;
        end else begin
            o_seg    <= {w_s0, w_e0, (w_p.count == 2'd1)};
            r_second <= {w_s1, w_e1, 1'b1};
        end
    end

    // a cell with two segments stalls intake for exactly one cycle
    a_hold_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold |=> !r_hold) else $error("hold longer than one beat");
    a_hold_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold |=> o_seg_strobe) else $error("second segment lost");
    a_busy_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !w_take) else $error("cell taken while busy");

endmodule

### tb/sv/marching_squares_cell_segments_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marching_squares_cell_segments_tb
// self-checking bench for the marching squares cell segment unit
// ----------------------------------------------------------------------------
// cells go in through a queue-fed driver, segment beats are caught by a
// monitor and compared with segments worked out by a local contour predictor
// for every accepted cell. the iso level is changed between phases while idle.
// ----------------------------------------------------------------------------
module marching_squares_cell_segments_tb;

    localparam int ClkHalf   = 10;
    localparam int Latency   = 40;
    localparam int CycleCap  = 400000;
    localparam int RandCells = 1400;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    mscs_pkg::t_cell cell_in;
    logic  cfg_valid;
    logic  cfg_ready;
    logic [mscs_pkg::LevelW-1:0] cfg_data;
    logic  seg_strobe;
    mscs_pkg::t_seg  seg_out;

    marching_squares_cell_segments dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_cell      (cell_in),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_seg_strobe(seg_strobe),
        .o_seg       (seg_out)
    );

    // predictor copy of the iso level
    logic signed [mscs_pkg::LevelW-1:0] iso_model;

    mscs_pkg::t_cell pending_cells[$];
    mscs_pkg::t_seg  expected_segs[$];
    int    mismatches;
    int    cycles;
    int    gap_left;
    bit    hold_sender;

    initial begin
        clk = 1'b0;
        forever #ClkHalf clk = ~clk;
    end

    // cycle counter, ends a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleCap) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    // crossing point on one edge, coordinate from cb towards ca
    function automatic logic signed [mscs_pkg::CoordW-1:0] edge_cross(
        input longint la, input longint lb, input longint ca, input longint cb);
        longint num, den, frac, prod;
        num = longint'(iso_model) - lb;
        den = la - lb;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        if (den == 0 || num <= 0) frac = 0;
        else begin
            frac = (num <<< 16) / den;
            if (frac > 65536) frac = 65536;
        end
        prod = frac * (ca - cb) + 32768;
        // arithmetic shift floors for negatives
        return mscs_pkg::CoordW'(cb + (prod >>> 16));
    endfunction

    task automatic edge_point(input mscs_pkg::t_edge e, input mscs_pkg::t_cell c,
                              output logic signed [mscs_pkg::CoordW-1:0] px,
                              output logic signed [mscs_pkg::CoordW-1:0] py);
        case (e)
            mscs_pkg::EDGE_A: begin
                px = edge_cross(c.level_00, c.level_10, c.x_low, c.x_high);
                py = c.y_low;
            end
            mscs_pkg::EDGE_B: begin
                px = c.x_low;
                py = edge_cross(c.level_00, c.level_01, c.y_low, c.y_high);
            end
            mscs_pkg::EDGE_C: begin
                px = edge_cross(c.level_01, c.level_11, c.x_low, c.x_high);
                py = c.y_high;
            end
            default: begin
                px = c.x_high;
                py = edge_cross(c.level_10, c.level_11, c.y_low, c.y_high);
            end
        endcase
    endtask

    // works out the segments one cell gives and queues them
    task automatic predict_segments(input mscs_pkg::t_cell c);
        logic [3:0] key;
        longint sum;
        mscs_pkg::t_edge ends[4];
        int n;
        mscs_pkg::t_seg s;
        key = {c.level_11 >= iso_model, c.level_10 >= iso_model,
               c.level_01 >= iso_model, c.level_00 >= iso_model};
        sum = longint'(c.level_00) + c.level_01 + c.level_10 + c.level_11;
        // saddle: join the high corners when the mean is above the level
        if (sum > 4 * longint'(iso_model)) begin
            if (key == 4'd6) key = 4'd9;
            else if (key == 4'd9) key = 4'd6;
        end
        n = 1;
        case (key)
            4'd0, 4'd15: n = 0;
            4'd1:  begin ends[0] = mscs_pkg::EDGE_B; ends[1] = mscs_pkg::EDGE_A; end
            4'd2, 4'd13: begin ends[0] = mscs_pkg::EDGE_B; ends[1] = mscs_pkg::EDGE_C; end
            4'd3, 4'd12: begin ends[0] = mscs_pkg::EDGE_A; ends[1] = mscs_pkg::EDGE_C; end
            4'd4, 4'd11: begin ends[0] = mscs_pkg::EDGE_A; ends[1] = mscs_pkg::EDGE_D; end
            4'd5, 4'd10: begin ends[0] = mscs_pkg::EDGE_B; ends[1] = mscs_pkg::EDGE_D; end
            4'd6: begin
                n = 2;
                ends[0] = mscs_pkg::EDGE_B; ends[1] = mscs_pkg::EDGE_C;
                ends[2] = mscs_pkg::EDGE_A; ends[3] = mscs_pkg::EDGE_D;
            end
            4'd7, 4'd8: begin ends[0] = mscs_pkg::EDGE_C; ends[1] = mscs_pkg::EDGE_D; end
            4'd9: begin
                n = 2;
                ends[0] = mscs_pkg::EDGE_C; ends[1] = mscs_pkg::EDGE_D;
                ends[2] = mscs_pkg::EDGE_B; ends[3] = mscs_pkg::EDGE_A;
            end
            default: begin ends[0] = mscs_pkg::EDGE_A; ends[1] = mscs_pkg::EDGE_B; end
        endcase
        for (int i = 0; i < n; i++) begin
            edge_point(ends[2*i], c, s.start_x, s.start_y);
            edge_point(ends[2*i+1], c, s.end_x, s.end_y);
            s.last_segment = (i == n - 1);
            expected_segs.push_back(s);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // driver: one cell beat per accepted start, random gaps in between
    always @(posedge clk) begin
        if (!rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else begin
            if (start && !busy) begin
                predict_segments(cell_in);
            end
            if (start && busy) begin
                // beat still pending, hold it
            end else if (hold_sender || pending_cells.size() == 0) begin
                start <= 1'b0;
            end else if (gap_left > 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else begin
                start    <= 1'b1;
                cell_in  <= pending_cells.pop_front();
                gap_left <= pick_gap();
            end
        end
    end

    // monitor: every strobe beat is checked against the oldest expectation
    always @(posedge clk) begin
        mscs_pkg::t_seg want;
        if (rst_n && seg_strobe) begin
            if (expected_segs.size() == 0) begin
                report_mismatch("segment beat with nothing expected");
            end else begin
                want = expected_segs.pop_front();
                if (seg_out.start_x !== want.start_x)
                    report_mismatch($sformatf("start_x %0d want %0d",
                        seg_out.start_x, want.start_x));
                if (seg_out.start_y !== want.start_y)
                    report_mismatch($sformatf("start_y %0d want %0d",
                        seg_out.start_y, want.start_y));
                if (seg_out.end_x !== want.end_x)
                    report_mismatch($sformatf("end_x %0d want %0d",
                        seg_out.end_x, want.end_x));
                if (seg_out.end_y !== want.end_y)
                    report_mismatch($sformatf("end_y %0d want %0d",
                        seg_out.end_y, want.end_y));
                if (seg_out.last_segment !== want.last_segment)
                    report_mismatch($sformatf("last_segment %0b want %0b",
                        seg_out.last_segment, want.last_segment));
            end
        end
    end

    function automatic logic signed [mscs_pkg::LevelW-1:0] rand_level();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'sh7FFF;
        if (r == 1) return 16'sh8000;
        if (r < 5)
            return mscs_pkg::LevelW'(int'(iso_model) + $urandom_range(0, 400) - 200);
        return mscs_pkg::LevelW'($urandom);
    endfunction

    function automatic mscs_pkg::t_cell rand_cell();
        mscs_pkg::t_cell c;
        int r;
        c.level_00 = rand_level();
        c.level_01 = rand_level();
        c.level_10 = rand_level();
        c.level_11 = rand_level();
        r = $urandom_range(0, 3);
        if (r == 0) begin
            c.x_low = mscs_pkg::CoordW'($urandom); c.x_high = mscs_pkg::CoordW'($urandom);
            c.y_low = mscs_pkg::CoordW'($urandom); c.y_high = mscs_pkg::CoordW'($urandom);
        end else begin
            // ordinary grid cell, unit-ish box
            c.x_low  = mscs_pkg::CoordW'($urandom_range(0, 8000000)) - 24'sd4000000;
            c.y_low  = mscs_pkg::CoordW'($urandom_range(0, 8000000)) - 24'sd4000000;
            c.x_high = c.x_low + mscs_pkg::CoordW'($urandom_range(1, 8192));
            c.y_high = c.y_low + mscs_pkg::CoordW'($urandom_range(1, 8192));
        end
        return c;
    endfunction

    function automatic mscs_pkg::t_cell make_cell(input int l00, l01, l10, l11);
        mscs_pkg::t_cell c;
        c.level_00 = mscs_pkg::LevelW'(l00); c.level_01 = mscs_pkg::LevelW'(l01);
        c.level_10 = mscs_pkg::LevelW'(l10); c.level_11 = mscs_pkg::LevelW'(l11);
        c.x_low = 24'sd0; c.x_high = 24'sd4096;
        c.y_low = 24'sd4096; c.y_high = 24'sd8192;
        return c;
    endfunction

    // waits for the pipe to drain, then writes the iso level
    task automatic set_iso(input logic signed [mscs_pkg::LevelW-1:0] lvl);
        while (pending_cells.size() != 0 || start || expected_segs.size() != 0)
            @(posedge clk);
        repeat (Latency) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= lvl;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        iso_model = lvl;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        mscs_pkg::t_cell c;
        logic signed [mscs_pkg::LevelW-1:0] iso_plan[6];
        iso_plan = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sd1234, -16'sd500, 16'sd0};
        rst_n       = 1'b0;
        start       = 1'b0;
        cell_in     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        mismatches  = 0;
        cycles      = 0;
        gap_left    = 0;
        hold_sender = 1'b0;
        iso_model   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every key, both saddle resolutions, extremes
        for (int k = 0; k < 16; k++)
            pending_cells.push_back(make_cell(k[0] ? 100 : -100, k[1] ? 50 : -300,
                                              k[2] ? 300 : -50, k[3] ? 7 : -1));
        pending_cells.push_back(make_cell(100, -300, -300, 100));   // saddle, mean low
        pending_cells.push_back(make_cell(-100, 300, 300, -100));   // saddle, mean high
        pending_cells.push_back(make_cell(300, -100, -100, 300));   // saddle, mean high
        pending_cells.push_back(make_cell(-32768, 32767, 32767, -32768));
        pending_cells.push_back(make_cell(0, -1, -1, 0));           // on the level
        c = make_cell(32767, -32768, -32768, -32768);
        c.x_low = 24'sh7FFFFF; c.x_high = 24'sh800000;              // reversed box
        c.y_low = 24'sh800000; c.y_high = 24'sh7FFFFF;
        pending_cells.push_back(c);

        for (int ph = 0; ph < 6; ph++) begin
            set_iso(iso_plan[ph]);
            for (int i = 0; i < RandCells / 6; i++)
                pending_cells.push_back(rand_cell());
            // halfway through one phase the sender holds until all is out
            if (ph == 3) begin
                while (pending_cells.size() > RandCells / 12) @(posedge clk);
                hold_sender = 1'b1;
                while (start || expected_segs.size() != 0) @(posedge clk);
                hold_sender = 1'b0;
            end
        end

        while (pending_cells.size() != 0 || start || expected_segs.size() != 0)
            @(posedge clk);
        repeat (Latency) @(posedge clk);
        if (mismatches == 0 && expected_segs.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
